[hdl/ots_pkg.sv]
// ots_pkg: types, constants and fixed-point helpers for the orbit trap shader.
// No dependencies; imported by every module under hdl/.
package ots_pkg;

	localparam int Q_FRAC = 24;          // Q8.24
	localparam int PROD_W = 40;          // floor(a*b / 2^24) for 32-bit a, b
	localparam int ACC_W  = 42;          // sums before saturation
	localparam int CNT_W  = 13;          // iteration count, up to limit + 1
	localparam int DIST_W = 31;
	localparam logic [29:0] SHADE_SCALE = 30'd671088630;
	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

	typedef enum logic [2:0] {
		CFG_PIXEL_STEP  = 3'd0,
		CFG_ORIGIN_REAL = 3'd1,
		CFG_ORIGIN_IMAG = 3'd2,
		CFG_ITER_LIMIT  = 3'd3,
		CFG_ESCAPE      = 3'd4,
		CFG_TRAP_REAL   = 3'd5,
		CFG_TRAP_IMAG   = 3'd6
	} ots_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAP,
		ST_ITER_A,
		ST_ITER_B,
		ST_SCALE,
		ST_DONE
	} ots_state_t;

	typedef struct packed {
		logic [24:0]        pixel_step;
		logic signed [31:0] origin_real;
		logic signed [31:0] origin_imag;
		logic [11:0]        iteration_limit;
		logic [30:0]        escape_bound;
		logic signed [31:0] trap_real;
		logic signed [31:0] trap_imag;
	} ots_cfg_t;

	typedef struct packed {
		logic map;    // latch c for the pixel in the coordinate registers
		logic init;   // z = 0
		logic step;   // z = z*z + c from the product cells
	} ots_ctl_t;

	function automatic logic signed [ACC_W-1:0] sx32(input logic [31:0] v);
		sx32 = $signed({{(ACC_W-32){v[31]}}, v});
	endfunction

	function automatic logic signed [ACC_W-1:0] sx40(input logic [PROD_W-1:0] v);
		sx40 = $signed({{(ACC_W-PROD_W){v[PROD_W-1]}}, v});
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
		if (v[ACC_W-1:31] == {(ACC_W-31){v[ACC_W-1]}})
			sat32 = v[31:0];
		else if (v[ACC_W-1])
			sat32 = 32'sh8000_0000;
		else
			sat32 = 32'sh7FFF_FFFF;
	endfunction

endpackage

[hdl/orbit_trap_pixel_shader.sv]
// Orbit trap pixel shader top: stream ports, config registers, sequencer, shade scaling.
// Depends on ots_pkg, ots_orbit.
// One pixel at a time. Each iteration runs the product cells, then the z update;
// the trap distance of each z lags one iteration and is tested in the product cycle.
// A zero iteration limit or escape bound skips the iterations. With the output free a new
// request is taken as soon as the result sits in the output register.
// arst_n clears the sequencer and output valid and loads the config registers' defaults.
module orbit_trap_pixel_shader import ots_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // [9:0] pixel_col, [19:10] pixel_row, [23:20] zero
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,   // [9:0] out_col, [19:10] out_row, [50:20] shade, zero
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [31:0] cfg_data
);

	ots_cfg_t          cfg_q;
	ots_ctl_t          ctl;
	ots_state_t        state_q, state_d;
	logic [9:0]        col_q, row_q;
	logic [CNT_W-1:0]  n_q, n_last;
	logic [DIST_W-1:0] dclip, d_q;
	logic [60:0]       prod_s1;
	logic [DIST_W-1:0] shade;
	logic              skip, stop, out_load, m_valid_q;
	logic [55:0]       m_data_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pixel_step      <= 25'd50332;
			cfg_q.origin_real     <= -32'sd36909875;
			cfg_q.origin_imag     <= -32'sd15099494;
			cfg_q.iteration_limit <= 12'd500;
			cfg_q.escape_bound    <= 31'd33554432;
			cfg_q.trap_real       <= -32'sd8388608;
			cfg_q.trap_imag       <= -32'sd2516582;
		end else if (cfg_we) begin
			unique case (ots_reg_t'(cfg_addr))
				CFG_PIXEL_STEP:  cfg_q.pixel_step      <= cfg_data[24:0];
				CFG_ORIGIN_REAL: cfg_q.origin_real     <= cfg_data;
				CFG_ORIGIN_IMAG: cfg_q.origin_imag     <= cfg_data;
				CFG_ITER_LIMIT:  cfg_q.iteration_limit <= cfg_data[11:0];
				CFG_ESCAPE:      cfg_q.escape_bound    <= cfg_data[30:0];
				CFG_TRAP_REAL:   cfg_q.trap_real       <= cfg_data;
				CFG_TRAP_IMAG:   cfg_q.trap_imag       <= cfg_data;
				default: ;
			endcase
		end
	end

	ots_orbit u_orbit (
		.clk   (clk),
		.cfg   (cfg_q),
		.ctl   (ctl),
		.col   (col_q),
		.row   (row_q),
		.dclip (dclip)
	);

	assign skip   = (cfg_q.iteration_limit == '0) || (cfg_q.escape_bound == '0);
	assign n_last = CNT_W'({1'b0, cfg_q.iteration_limit}) + CNT_W'(1);
	// distance in the cells belongs to z number n_q - 1
	assign stop   = (n_q >= CNT_W'(2)) && ((dclip >= cfg_q.escape_bound) || (n_q == n_last));
	assign out_load = (state_q == ST_DONE) && (!m_valid_q || m_axis_tready);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (s_axis_tvalid) state_d = ST_MAP;
			ST_MAP:    state_d = skip ? ST_SCALE : ST_ITER_A;
			ST_ITER_A: state_d = stop ? ST_SCALE : ST_ITER_B;
			ST_ITER_B: state_d = ST_ITER_A;
			ST_SCALE:  state_d = ST_DONE;
			ST_DONE:   if (out_load) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		ctl.map       = (state_q == ST_MAP);
		ctl.init      = (state_q == ST_MAP);
		ctl.step      = (state_q == ST_ITER_B);
		s_axis_tready = (state_q == ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			n_q       <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_MAP)
				n_q <= '0;
			else if (state_q == ST_ITER_B)
				n_q <= n_q + CNT_W'(1);
			if (out_load)
				m_valid_q <= 1'b1;
			else if (m_axis_tready)
				m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			col_q <= s_axis_tdata[9:0];
			row_q <= s_axis_tdata[19:10];
		end
		if (state_q == ST_MAP && skip)
			d_q <= '0;
		else if (state_q == ST_ITER_A && stop)
			d_q <= dclip;
		prod_s1 <= d_q * SHADE_SCALE;
		if (out_load)
			m_data_q <= {5'b0, shade, row_q, col_q};
	end

	assign shade = (|prod_s1[60:55]) ? DIST_MAX : prod_s1[54:24];

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ITER_A) |-> (n_q <= n_last))
		else $error("iteration count past limit");

	a_accept_map: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> (state_q == ST_MAP))
		else $error("accepted request did not start mapping");

	a_iter_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ITER_B) |=> (state_q == ST_ITER_A))
		else $error("z update not followed by product cycle");

	a_result_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (m_axis_tvalid && state_q == ST_IDLE))
		else $error("finished pixel not presented");

endmodule

[hdl/ots_qmul.sv]
// ots_qmul: product cell, registered floor(a*b / 2^24) of two signed Q8.24 values.
// Depends on ots_pkg.
module ots_qmul import ots_pkg::*; (
	input  logic                     clk,
	input  logic signed [31:0]       a,
	input  logic signed [31:0]       b,
	output logic signed [PROD_W-1:0] p_q
);

	logic signed [63:0] full;

	assign full = a * b;

	// arithmetic shift of the exact product: rounds toward minus infinity
	always_ff @(posedge clk) begin
		p_q <= full[63:Q_FRAC];
	end

endmodule

[hdl/ots_orbit.sv]
// ots_orbit: point mapping, z registers and the row of product cells.
// z feeds three cells, the trap offset feeds two; depends on ots_pkg, ots_qmul.
module ots_orbit import ots_pkg::*; (
	input  logic              clk,
	input  ots_cfg_t          cfg,
	input  ots_ctl_t          ctl,
	input  logic [9:0]        col,
	input  logic [9:0]        row,
	output logic [DIST_W-1:0] dclip
);

	logic signed [31:0]       cr_q, ci_q, zr_q, zi_q, dr_q, di_q;
	logic signed [PROD_W-1:0] zrr_q, zii_q, zri_q, drr_q, dii_q;
	logic [34:0]              col_off, row_off;
	logic signed [ACC_W-1:0]  cr_sum, ci_sum, zr_sum, zi_sum, dr_sum, di_sum;
	logic [PROD_W-1:0]        dsum;

	assign col_off = col * cfg.pixel_step;
	assign row_off = row * cfg.pixel_step;
	assign cr_sum  = sx32(cfg.origin_real) + $signed({{(ACC_W-35){1'b0}}, col_off});
	assign ci_sum  = sx32(cfg.origin_imag) + $signed({{(ACC_W-35){1'b0}}, row_off});

	assign zr_sum  = sx32(cr_q) + sx40(zrr_q) - sx40(zii_q);
	assign zi_sum  = sx32(ci_q) + (sx40(zri_q) <<< 1);

	assign dr_sum  = sx32(zr_q) - sx32(cfg.trap_real);
	assign di_sum  = sx32(zi_q) - sx32(cfg.trap_imag);

	always_ff @(posedge clk) begin
		if (ctl.map) begin
			cr_q <= sat32(cr_sum);
			ci_q <= sat32(ci_sum);
		end
		if (ctl.init) begin
			zr_q <= '0;
			zi_q <= '0;
		end else if (ctl.step) begin
			zr_q <= sat32(zr_sum);
			zi_q <= sat32(zi_sum);
		end
		dr_q <= sat32(dr_sum);
		di_q <= sat32(di_sum);
	end

	ots_qmul u_zrr (.clk(clk), .a(zr_q), .b(zr_q), .p_q(zrr_q));
	ots_qmul u_zii (.clk(clk), .a(zi_q), .b(zi_q), .p_q(zii_q));
	ots_qmul u_zri (.clk(clk), .a(zr_q), .b(zi_q), .p_q(zri_q));
	ots_qmul u_drr (.clk(clk), .a(dr_q), .b(dr_q), .p_q(drr_q));
	ots_qmul u_dii (.clk(clk), .a(di_q), .b(di_q), .p_q(dii_q));

	// squares are non-negative and below 2^39
	assign dsum  = {1'b0, drr_q[PROD_W-2:0]} + {1'b0, dii_q[PROD_W-2:0]};
	assign dclip = (|dsum[PROD_W-1:DIST_W]) ? DIST_MAX : dsum[DIST_W-1:0];

endmodule

[sim/tb_orbit_trap_pixel_shader.sv]
// Self-checking bench for orbit_trap_pixel_shader: pixel requests in, shaded pixels out.
// Depends on ots_pkg and orbit_trap_pixel_shader; predicts each shade from a local
// copy of the register file and checks results in order under random idling and stalls.
module tb_orbit_trap_pixel_shader import ots_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] CFG_UNUSED = 3'd7;
	localparam longint SHADE_GAIN = 671088630;
	localparam longint DIST_CAP = 64'd2147483647;
	localparam int RANDOM_ITEMS = 1140;

	typedef struct packed {
		logic [30:0] shade;
		logic [9:0]  row;
		logic [9:0]  col;
	} shaded_pixel_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;   // [9:0] pixel_col, [19:10] pixel_row, [23:20] zero
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [55:0] m_axis_tdata;        // [9:0] out_col, [19:10] out_row, [50:20] shade
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_addr = '0;
	logic [31:0] cfg_data = '0;

	ots_cfg_t      shadow_cfg;
	logic [19:0]   pending_pixels[$];  // {row, col}
	shaded_pixel_t expected_shades[$];
	int            items_issued = 0;
	int            results_checked = 0;
	int            fail_count = 0;
	int            send_gap = 0;
	int            stall_left = 0;
	bit            steady = 1'b0;

	orbit_trap_pixel_shader dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	// Q8.24 product, floor
	function automatic longint qprod(input longint a, input longint b);
		return (a * b) >>> Q_FRAC;
	endfunction

	function automatic logic [30:0] trap_shade(input logic [9:0] col, input logic [9:0] row);
		longint cr, ci, zr, zi, nr, ni, dr, di, d, s;
		int unsigned n;
		cr = clamp32(longint'($signed(shadow_cfg.origin_real))
			+ longint'(col) * longint'(shadow_cfg.pixel_step));
		ci = clamp32(longint'($signed(shadow_cfg.origin_imag))
			+ longint'(row) * longint'(shadow_cfg.pixel_step));
		zr = 0;
		zi = 0;
		d = 0;
		n = 0;
		while (n < shadow_cfg.iteration_limit && d < longint'(shadow_cfg.escape_bound)) begin
			nr = clamp32(cr + qprod(zr, zr) - qprod(zi, zi));
			ni = clamp32(ci + 2 * qprod(zr, zi));
			zr = nr;
			zi = ni;
			dr = clamp32(zr - longint'($signed(shadow_cfg.trap_real)));
			di = clamp32(zi - longint'($signed(shadow_cfg.trap_imag)));
			d = qprod(dr, dr) + qprod(di, di);
			if (d > DIST_CAP)
				d = DIST_CAP;
			n++;
		end
		s = (d * SHADE_GAIN) >>> Q_FRAC;
		if (s > DIST_CAP)
			s = DIST_CAP;
		return s[30:0];
	endfunction

	// request side: predict on acceptance, idle only between requests
	always @(posedge clk or negedge arst_n) begin : request_driver
		logic [9:0] col, row;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			send_gap <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				col = s_axis_tdata[9:0];
				row = s_axis_tdata[19:10];
				expected_shades.push_back('{shade: trap_shade(col, row), row: row, col: col});
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					s_axis_tvalid <= 1'b0;
				end else if (!steady && pending_pixels.size() > 0 && $urandom_range(0, 7) == 0) begin
					send_gap <= $urandom_range(0, 6);
					s_axis_tvalid <= 1'b0;
				end else if (pending_pixels.size() > 0) begin
					s_axis_tdata <= {4'b0, pending_pixels.pop_front()};
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// result side: in-order check, random backpressure
	always @(posedge clk or negedge arst_n) begin : result_monitor
		shaded_pixel_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_shades.size() == 0) begin
					$error("result with no request pending: %h", m_axis_tdata);
					fail_count++;
				end else begin
					want = expected_shades.pop_front();
					if (m_axis_tdata[9:0] !== want.col) begin
						$error("out_col mismatch: expected %0d, got %0d", want.col, m_axis_tdata[9:0]);
						fail_count++;
					end
					if (m_axis_tdata[19:10] !== want.row) begin
						$error("out_row mismatch: expected %0d, got %0d", want.row,
							m_axis_tdata[19:10]);
						fail_count++;
					end
					if (m_axis_tdata[50:20] !== want.shade) begin
						$error("shade mismatch: expected %0d, got %0d", want.shade,
							m_axis_tdata[50:20]);
						fail_count++;
					end
					results_checked++;
				end
			end
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				m_axis_tready <= 1'b0;
			end else if (!steady && $urandom_range(0, 5) == 0) begin
				stall_left <= $urandom_range(0, 6);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= data;
		case (idx)
			CFG_PIXEL_STEP:  shadow_cfg.pixel_step = data[24:0];
			CFG_ORIGIN_REAL: shadow_cfg.origin_real = data;
			CFG_ORIGIN_IMAG: shadow_cfg.origin_imag = data;
			CFG_ITER_LIMIT:  shadow_cfg.iteration_limit = data[11:0];
			CFG_ESCAPE:      shadow_cfg.escape_bound = data[30:0];
			CFG_TRAP_REAL:   shadow_cfg.trap_real = data;
			CFG_TRAP_IMAG:   shadow_cfg.trap_imag = data;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_pixel(input logic [9:0] col, input logic [9:0] row);
		pending_pixels.push_back({row, col});
		items_issued++;
	endtask

	task automatic drain();
		wait (results_checked == items_issued);
		repeat (4) @(posedge clk);
	endtask

	// kind: 0..6 short orbits, 7 medium, 8 zero limit or zero bound, 9 full limit
	task automatic run_phase(input int kind, output int n_items);
		logic [11:0] lim;
		logic [31:0] esc;
		bit          wild;
		drain();
		wild = ($urandom_range(0, 2) == 0);
		case (kind)
			7: begin
				lim = 12'($urandom_range(33, 500));
				n_items = 8;
			end
			8: begin
				lim = $urandom_range(0, 1) ? 12'd0 : 12'($urandom_range(1, 16));
				n_items = 20;
			end
			9: begin
				lim = 12'd4095;
				n_items = 2;
			end
			default: begin
				lim = 12'($urandom_range(1, 32));
				n_items = 60;
			end
		endcase
		esc = wild ? $urandom : $urandom_range(0, 268435456);
		if (kind == 8 && lim != 0)
			esc = '0;
		if (wild) begin
			write_reg(CFG_PIXEL_STEP, $urandom);
			write_reg(CFG_ORIGIN_REAL, $urandom);
			write_reg(CFG_ORIGIN_IMAG, $urandom);
			write_reg(CFG_TRAP_REAL, $urandom);
			write_reg(CFG_TRAP_IMAG, $urandom);
		end else begin
			write_reg(CFG_PIXEL_STEP, $urandom_range(1, 65536));
			write_reg(CFG_ORIGIN_REAL, int'($urandom_range(0, 50331648)) - 41943040);
			write_reg(CFG_ORIGIN_IMAG, int'($urandom_range(0, 33554432)) - 25165824);
			write_reg(CFG_TRAP_REAL, int'($urandom_range(0, 67108864)) - 33554432);
			write_reg(CFG_TRAP_IMAG, int'($urandom_range(0, 67108864)) - 33554432);
		end
		write_reg(CFG_ITER_LIMIT, ($urandom & 32'hFFFF_F000) | 32'(lim));
		write_reg(CFG_ESCAPE, esc);
		if ($urandom_range(0, 3) == 0)
			write_reg(CFG_UNUSED, $urandom);
		repeat (n_items) begin
			if ($urandom_range(0, 4) == 0)
				queue_pixel(10'($urandom_range(0, 1023)), 10'($urandom_range(768, 1023)));
			else
				queue_pixel(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 767)));
		end
	endtask

	initial begin : stimulus
		int phase, n, random_items;
		shadow_cfg.pixel_step = 25'd50332;
		shadow_cfg.origin_real = -32'sd36909875;
		shadow_cfg.origin_imag = -32'sd15099494;
		shadow_cfg.iteration_limit = 12'd500;
		shadow_cfg.escape_bound = 31'd33554432;
		shadow_cfg.trap_real = -32'sd8388608;
		shadow_cfg.trap_imag = -32'sd2516582;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset view, coordinate corners and beyond the raster
		queue_pixel(10'd0, 10'd0);
		queue_pixel(10'd1023, 10'd767);
		queue_pixel(10'd512, 10'd384);
		queue_pixel(10'd1023, 10'd1023);
		queue_pixel(10'd0, 10'd1023);
		queue_pixel(10'd341, 10'd682);
		drain();

		// zero step: every pixel at c = 0, trap kept inside the bound -> full count
		write_reg(CFG_PIXEL_STEP, 32'd0);
		write_reg(CFG_ORIGIN_REAL, 32'd0);
		write_reg(CFG_ORIGIN_IMAG, 32'd0);
		write_reg(CFG_ITER_LIMIT, 32'd4095);
		write_reg(CFG_ESCAPE, 32'hFFFF_FFFF);
		write_reg(CFG_TRAP_REAL, 32'd16777216);
		write_reg(CFG_TRAP_IMAG, 32'd0);
		queue_pixel(10'd1023, 10'd1023);
		queue_pixel(10'd5, 10'd9);
		drain();

		// zero escape bound, then zero limit via a masked write, ignored index
		write_reg(CFG_ESCAPE, 32'd0);
		queue_pixel(10'd100, 10'd100);
		drain();
		write_reg(CFG_ESCAPE, 32'd33554432);
		write_reg(CFG_ITER_LIMIT, 32'h0000_1000);
		write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
		queue_pixel(10'd200, 10'd300);
		drain();

		// saturation at both ends of the plane
		write_reg(CFG_PIXEL_STEP, 32'hFFFF_FFFF);
		write_reg(CFG_ORIGIN_REAL, 32'h7FFF_FFFF);
		write_reg(CFG_ORIGIN_IMAG, 32'h8000_0000);
		write_reg(CFG_ITER_LIMIT, 32'd8);
		write_reg(CFG_ESCAPE, 32'h7FFF_FFFF);
		write_reg(CFG_TRAP_REAL, 32'h8000_0000);
		write_reg(CFG_TRAP_IMAG, 32'h7FFF_FFFF);
		queue_pixel(10'd1023, 10'd1023);
		queue_pixel(10'd0, 10'd0);
		queue_pixel(10'd1, 10'd0);
		drain();
		write_reg(CFG_PIXEL_STEP, 32'd16777216);
		write_reg(CFG_ORIGIN_REAL, 32'h8000_0000);
		write_reg(CFG_ORIGIN_IMAG, 32'h7FFF_FFFF);
		queue_pixel(10'd1023, 10'd767);
		queue_pixel(10'd0, 10'd1023);

		phase = 0;
		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			run_phase(phase % 10, n);
			random_items += n;
			phase++;
		end
		drain();
		steady = 1'b1;
		run_phase(0, n);

		wait (results_checked == items_issued);
		repeat (2 * shadow_cfg.iteration_limit + 16) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin : watchdog
		#8_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
